// ===== rtl/mtt_pkg.sv =====
package mtt_pkg;

    // Table geometry and field widths.
    localparam int TIMER_SLOTS = 16;
    localparam int ID_BITS     = 16;
    localparam int MAX_RESULTS = 16;
    localparam int INTERVAL_W  = 24;
    localparam int OUT_ID_W    = 16;
    localparam int OP_W        = 2;
    localparam int KIND_W      = 2;

    localparam int ADDR_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CNT_W  = $clog2(TIMER_SLOTS + 1);
    localparam int FC_W   = $clog2(MAX_RESULTS + 1);
    localparam int CMP_W  = (ID_BITS > OUT_ID_W) ? ID_BITS : OUT_ID_W;

    localparam logic [INTERVAL_W-1:0] ELAPSED_MAX = {INTERVAL_W{1'b1}};

    // Input operations.
    localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
    localparam logic [OP_W-1:0] OP_DEL  = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK = 2'd2;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_ADD_OK = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FULL   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIRE   = 2'd2;

    typedef struct packed {
        logic [ID_BITS-1:0]    id;
        logic [INTERVAL_W-1:0] interval;
        logic [INTERVAL_W-1:0] elapsed;
        logic                  periodic;
        logic                  first_due;
    } mtt_entry_t;

    // Verdict of the shared update unit on one entry.
    typedef struct packed {
        logic       keep;
        logic       emit;
        logic       match;
        mtt_entry_t ent;
    } mtt_step_t;

endpackage

// ===== rtl/multi_timer_table.sv =====
// An add's result word is held in the ADD state and loaded into the output register once that is free.
// A delete or tick walks the n live entries in a read/compact pass; each fire word is held
// until the next fire or the end of the pass.
// The block takes one input word at a time: s_tready is high only in idle, and a stalled
// result channel holds the add response and the scan.
// Reset (aresetn low, synchronous) empties the table and clears the id counter.
module multi_timer_table
    import mtt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // interval_ms[23:0], periodic[24], target_id[40:25]
    input  logic [1:0]  s_tuser,   // op[1:0]
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // timer_id[15:0]
    output logic [1:0]  m_tuser,   // kind[1:0]
    output logic        m_tlast    // last
);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;
    localparam logic [1:0] ST_ADD   = 2'd3;

    // Input word fields.
    logic [OP_W-1:0]       s_op;
    logic [INTERVAL_W-1:0] s_interval_ms;
    logic                  s_periodic;
    logic [OUT_ID_W-1:0]   s_target_id;

    assign s_op          = s_tuser;
    assign s_interval_ms = s_tdata[23:0];
    assign s_periodic    = s_tdata[24];
    assign s_target_id   = s_tdata[40:25];

    // Control state.
    logic [1:0]         state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic               pv_reg, pv_next;
    logic               tick_mode_reg, tick_mode_next;
    logic               found_reg, found_next;
    logic [FC_W-1:0]    fc_reg, fc_next;
    logic               hold_valid_reg, hold_valid_next;
    logic [ID_BITS-1:0] next_id_reg, next_id_next;
    logic               m_tvalid_reg, m_tvalid_next;

    // Payload state.
    logic [OUT_ID_W-1:0] hold_id_reg, hold_id_next;
    logic [OUT_ID_W-1:0] target_reg, target_next;
    logic [KIND_W-1:0]   resp_kind_reg, resp_kind_next;
    logic [OUT_ID_W-1:0] resp_id_reg, resp_id_next;
    logic [KIND_W-1:0]   m_kind_reg;
    logic [OUT_ID_W-1:0] m_id_reg;
    logic                m_last_reg;

    // Slot RAM port signals.
    logic              mem_wen;
    logic [ADDR_W-1:0] mem_waddr;
    mtt_entry_t        mem_wdata;
    logic              mem_ren;
    mtt_entry_t        rd_ent;

    mtt_step_t           step;
    logic                out_free;
    logic                out_load;
    logic [KIND_W-1:0]   out_kind;
    logic [OUT_ID_W-1:0] out_id;
    logic                out_last;
    logic                issue;
    logic                stall;
    logic [ID_BITS-1:0]  id_new;

    mtt_slot_ram u_ram (
        .aclk  (aclk),
        .wen   (mem_wen),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .ren   (mem_ren),
        .raddr (rd_ptr_reg[ADDR_W-1:0]),
        .rdata (rd_ent)
    );

    // One entry per cycle, unless the scan is stalled, goes through the shared update unit.
    mtt_update_unit u_update (
        .ent        (rd_ent),
        .tick_mode  (tick_mode_reg),
        .fire_allow (fc_reg < FC_W'(MAX_RESULTS)),
        .found      (found_reg),
        .target_id  (target_reg),
        .step       (step)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;
    assign issue    = (rd_ptr_reg < count_reg);
    assign stall    = pv_reg && step.emit && hold_valid_reg && !out_free;
    assign id_new   = next_id_reg + ID_BITS'(1);

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        rd_ptr_next     = rd_ptr_reg;
        wr_ptr_next     = wr_ptr_reg;
        pv_next         = pv_reg;
        tick_mode_next  = tick_mode_reg;
        found_next      = found_reg;
        fc_next         = fc_reg;
        hold_valid_next = hold_valid_reg;
        next_id_next    = next_id_reg;
        hold_id_next    = hold_id_reg;
        target_next     = target_reg;
        resp_kind_next  = resp_kind_reg;
        resp_id_next    = resp_id_reg;
        mem_wen         = 1'b0;
        mem_waddr       = wr_ptr_reg[ADDR_W-1:0];
        mem_wdata       = step.ent;
        mem_ren         = 1'b0;
        out_load        = 1'b0;
        out_kind        = KIND_FIRE;
        out_id          = hold_id_reg;
        out_last        = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    case (s_op)
                        OP_ADD: begin
                            if (count_reg == CNT_W'(TIMER_SLOTS)) begin
                                resp_kind_next = KIND_FULL;
                                resp_id_next   = '0;
                            end else begin
                                next_id_next       = id_new;
                                mem_wen            = 1'b1;
                                mem_waddr          = count_reg[ADDR_W-1:0];
                                mem_wdata.id        = id_new;
                                mem_wdata.interval  = s_interval_ms;
                                mem_wdata.elapsed   = '0;
                                mem_wdata.periodic  = s_periodic;
                                mem_wdata.first_due = s_periodic;
                                count_next         = count_reg + CNT_W'(1);
                                resp_kind_next     = KIND_ADD_OK;
                                resp_id_next       = OUT_ID_W'(id_new);
                            end
                            state_next = ST_ADD;
                        end
                        OP_DEL, OP_TICK: begin
                            tick_mode_next = (s_op == OP_TICK);
                            target_next    = s_target_id;
                            found_next     = 1'b0;
                            fc_next        = '0;
                            rd_ptr_next    = '0;
                            wr_ptr_next    = '0;
                            pv_next        = 1'b0;
                            state_next     = ST_SCAN;
                        end
                        default: begin
                            // The unused op code is taken and dropped.
                        end
                    endcase
                end
            end
            ST_ADD: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_kind   = resp_kind_reg;
                    out_id     = resp_id_reg;
                    out_last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (!stall) begin
                    mem_ren     = issue;
                    rd_ptr_next = issue ? rd_ptr_reg + CNT_W'(1) : rd_ptr_reg;
                    pv_next     = issue;
                    if (pv_reg) begin
                        if (step.match) begin
                            found_next = 1'b1;
                        end
                        // Kept entries are written back compacted.
                        if (step.keep) begin
                            mem_wen     = 1'b1;
                            wr_ptr_next = wr_ptr_reg + CNT_W'(1);
                        end
                        if (step.emit) begin
                            fc_next = fc_reg + FC_W'(1);
                            // The held fire is not the last one, since another follows.
                            if (hold_valid_reg) begin
                                out_load = 1'b1;
                            end
                            hold_valid_next = 1'b1;
                            hold_id_next    = OUT_ID_W'(step.ent.id);
                        end
                    end else if (!issue) begin
                        count_next = wr_ptr_reg;
                        state_next = hold_valid_reg ? ST_FLUSH : ST_IDLE;
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    out_load        = 1'b1;
                    out_last        = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            rd_ptr_reg     <= '0;
            wr_ptr_reg     <= '0;
            pv_reg         <= 1'b0;
            tick_mode_reg  <= 1'b0;
            found_reg      <= 1'b0;
            fc_reg         <= '0;
            hold_valid_reg <= 1'b0;
            next_id_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            rd_ptr_reg     <= rd_ptr_next;
            wr_ptr_reg     <= wr_ptr_next;
            pv_reg         <= pv_next;
            tick_mode_reg  <= tick_mode_next;
            found_reg      <= found_next;
            fc_reg         <= fc_next;
            hold_valid_reg <= hold_valid_next;
            next_id_reg    <= next_id_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_id_reg   <= hold_id_next;
        target_reg    <= target_next;
        resp_kind_reg <= resp_kind_next;
        resp_id_reg   <= resp_id_next;
        if (out_load) begin
            m_kind_reg <= out_kind;
            m_id_reg   <= out_id;
            m_last_reg <= out_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = m_id_reg;
    assign m_tlast  = m_last_reg;

    // The compaction write pointer never passes the read pointer.
    a_wr_behind_rd: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_ptr_reg <= rd_ptr_reg)
        else $error("write pointer overtook read pointer");

    // The live count never exceeds the table size.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TIMER_SLOTS))
        else $error("live count out of range");

    // No fire word is left held once the sequencer is back in idle.
    a_idle_no_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !hold_valid_reg)
        else $error("held fire left behind in idle");

    // The live count only changes at the end of a pass, not during it.
    a_count_stable_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && $past(state_reg) == ST_SCAN) |-> $stable(count_reg))
        else $error("live count changed mid pass");

endmodule

// ===== rtl/mtt_slot_ram.sv =====
module mtt_slot_ram
    import mtt_pkg::*;
(
    input  logic              aclk,
    input  logic              wen,
    input  logic [ADDR_W-1:0] waddr,
    input  mtt_entry_t        wdata,
    input  logic              ren,
    input  logic [ADDR_W-1:0] raddr,
    output mtt_entry_t        rdata
);

    mtt_entry_t mem [TIMER_SLOTS];
    mtt_entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (wen) begin
            mem[waddr] <= wdata;
        end
    end

    // Read data holds while the scan is stalled.
    always_ff @(posedge aclk) begin
        if (ren) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/mtt_update_unit.sv =====
module mtt_update_unit
    import mtt_pkg::*;
(
    input  mtt_entry_t          ent,
    input  logic                tick_mode,
    input  logic                fire_allow,
    input  logic                found,
    input  logic [OUT_ID_W-1:0] target_id,
    output mtt_step_t           step
);

    logic [INTERVAL_W-1:0] el_inc;
    logic                  due;

    always_comb begin
        el_inc = (ent.elapsed == ELAPSED_MAX) ? ent.elapsed
                                              : ent.elapsed + INTERVAL_W'(1);
        due    = ent.first_due || (el_inc >= ent.interval);
        step       = '0;
        step.ent   = ent;
        if (tick_mode) begin
            step.ent.elapsed = el_inc;
            if (due && fire_allow) begin
                step.emit = 1'b1;
                step.keep = ent.periodic;
                step.ent.elapsed   = '0;
                step.ent.first_due = 1'b0;
            end else begin
                step.keep = 1'b1;
            end
        end else begin
            // Delete removes only the oldest matching entry.
            step.match = !found && (CMP_W'(ent.id) == CMP_W'(target_id));
            step.keep  = !step.match;
        end
    end

endmodule
